// ===== rtl/seib_pkg.sv =====
// Shared types, constants and the taper weight table of the soft ellipse blend.
`default_nettype none
package seib_pkg;

    // Field widths.
    localparam int VALUE_W = 16;
    localparam int COORD_W = 32;
    localparam int AXIS_W = 2;
    localparam int TRANS_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Offset magnitudes are clamped to this width; their squares are twice as wide.
    localparam int MAG_W = 32;
    localparam int SQ_W = 2 * MAG_W;

    // Each quotient term is floor(sq * 2^QSHIFT / div); q saturates at 2^Q_W.
    localparam int QSHIFT = 8;
    localparam int Q_W = 48;
    localparam int QHI_W = SQ_W + QSHIFT - Q_W;
    localparam int QD_STEPS = Q_W;

    // q is Q.16, so one is 2^16.
    localparam int QF = 16;
    localparam logic [Q_W:0] Q_CAP = {1'b1, {Q_W{1'b0}}};
    localparam logic [QF:0] Q_ONE = {1'b1, {QF{1'b0}}};

    // Taper table; the depth must be a power of two.
    localparam int TAPER_DEPTH = 256;
    localparam int TAPER_LOG = $clog2(TAPER_DEPTH);
    localparam int IDX_W = TAPER_LOG + 1;
    localparam int NUM_W = TRANS_W + 1;

    // Weight in Q1.15.
    localparam int W_W = 16;
    localparam logic [W_W-1:0] W_ONE = 16'd32768;
    localparam int ACC_W = VALUE_W + W_W + 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Q = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_SQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_SQ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd6;

    // Axis codes.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Depth of the queue between front and back.
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW = $clog2(FQ_DEPTH);

    // One item as the front hands it to the back.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SQ_W-1:0]    sq_p;
        logic [SQ_W-1:0]    sq_r;
    } t_front_item;

    // Configuration the back needs.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] a_sq;
        logic [CFG_DATA_W-1:0] b_sq;
        logic [TRANS_W-1:0]    trans;
        logic [VALUE_W-1:0]    target;
    } t_back_cfg;

    typedef logic [TAPER_DEPTH:0][W_W-1:0] t_taper_tab;

    // Shift-and-subtract quotient used while the table is built.
    function automatic longint unsigned series_quot(longint unsigned n, longint unsigned d);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((n >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= d) begin
                rem = rem - d;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Cosine taper built from a truncated Q2.30 series, rounded to Q1.15.
    function automatic t_taper_tab build_taper();
        t_taper_tab        tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            w;
        tab = '0;
        for (int i = 0; i <= TAPER_DEPTH; i++) begin
            x = (64'd1686629713 * longint'(i)) >> TAPER_LOG;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = longint'(term);
            for (int k = 1; k <= 8; k++) begin
                term = series_quot((term * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            w = (sum + 16384) >>> 15;
            if (w > 32768) begin
                w = 32768;
            end
            tab[i] = w[W_W-1:0];
        end
        return tab;
    endfunction

    localparam t_taper_tab TAPER_TAB = build_taper();

endpackage
`default_nettype wire

// ===== rtl/seib_front.sv =====
// Front part: accepts voxels, picks the in-plane offsets and squares them.
`default_nettype none
module seib_front import seib_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [VALUE_W-1:0]    i_voxel_value,
    input  wire logic [COORD_W-1:0]    i_coord_x,
    input  wire logic [COORD_W-1:0]    i_coord_y,
    input  wire logic [COORD_W-1:0]    i_coord_z,
    input  wire logic [AXIS_W-1:0]     i_axis,
    input  wire logic [COORD_W-1:0]    i_center_p,
    input  wire logic [COORD_W-1:0]    i_center_q,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_front_item                o_q_item
);

    logic                 en;
    logic [COORD_W-1:0]   sel_p;
    logic [COORD_W-1:0]   sel_r;
    logic [COORD_W:0]     d_p;
    logic [COORD_W:0]     d_r;
    logic [COORD_W:0]     abs_p;
    logic [COORD_W:0]     abs_r;
    logic [MAG_W-1:0]     mag_p;
    logic [MAG_W-1:0]     mag_r;

    logic                 r_f1_valid;
    logic [VALUE_W-1:0]   r_f1_value;
    logic [MAG_W-1:0]     r_f1_mag_p;
    logic [MAG_W-1:0]     r_f1_mag_r;
    logic                 r_f2_valid;
    t_front_item          r_f2_item;

    // Both stages move unless a finished item cannot enter the queue.
    assign en = !(r_f2_valid && i_q_full);
    assign full = !en;

    // Pick the two coordinates across the cylinder axis.
    always_comb begin
        case (i_axis)
            AXIS_X: begin
                sel_p = i_coord_y;
                sel_r = i_coord_z;
            end
            AXIS_Y: begin
                sel_p = i_coord_x;
                sel_r = i_coord_z;
            end
            default: begin
                sel_p = i_coord_x;
                sel_r = i_coord_y;
            end
        endcase
    end

    // Offsets from the center, as clamped magnitudes.
    always_comb begin
        d_p = {sel_p[COORD_W-1], sel_p} - {i_center_p[COORD_W-1], i_center_p};
        d_r = {sel_r[COORD_W-1], sel_r} - {i_center_q[COORD_W-1], i_center_q};
        abs_p = d_p[COORD_W] ? (~d_p + 1'b1) : d_p;
        abs_r = d_r[COORD_W] ? (~d_r + 1'b1) : d_r;
        mag_p = abs_p[COORD_W] ? {MAG_W{1'b1}} : abs_p[MAG_W-1:0];
        mag_r = abs_r[COORD_W] ? {MAG_W{1'b1}} : abs_r[MAG_W-1:0];
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= push;
            r_f2_valid <= r_f1_valid;
        end
    end

    // Offset stage, then the squaring stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_value <= i_voxel_value;
            r_f1_mag_p <= mag_p;
            r_f1_mag_r <= mag_r;
            r_f2_item.value <= r_f1_value;
            r_f2_item.sq_p <= r_f1_mag_p * r_f1_mag_p;
            r_f2_item.sq_r <= r_f1_mag_r * r_f1_mag_r;
        end
    end

    assign o_q_push = en && r_f2_valid;
    assign o_q_item = r_f2_item;

endmodule
`default_nettype wire

// ===== rtl/seib_fifo.sv =====
// Short queue of front items between the front and the back.
`default_nettype none
module seib_fifo import seib_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_front_item  i_item,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_empty,
    output t_front_item  o_item
);

    t_front_item        r_mem [0:FQ_DEPTH-1];
    logic [FQ_AW-1:0]   r_wp;
    logic [FQ_AW-1:0]   r_rp;
    logic [FQ_AW:0]     r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_item = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/seib_qdiv.sv =====
// Pipelined restoring divider: floor(sq * 256 / div), one quotient bit a stage.
`default_nettype none
module seib_qdiv import seib_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [SQ_W-1:0]       i_sq,
    input  wire logic [CFG_DATA_W-1:0] i_div,
    output logic [Q_W-1:0]             o_quo,
    output logic                       o_sat
);

    logic [CFG_DATA_W-1:0] div;
    logic [CFG_DATA_W-1:0] r_rem  [0:QD_STEPS];
    logic [Q_W-1:0]        r_bits [0:QD_STEPS];
    logic                  r_sat  [0:QD_STEPS];

    // A zero divisor acts as one.
    assign div = (i_div == '0) ? CFG_DATA_W'(1) : i_div;

    // Load: the high part starts the remainder; saturate if it already reaches div.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CFG_DATA_W'(i_sq[SQ_W-1 -: QHI_W]);
            r_bits[0] <= {i_sq[Q_W-QSHIFT-1:0], {QSHIFT{1'b0}}};
            r_sat[0] <= (CFG_DATA_W'(i_sq[SQ_W-1 -: QHI_W]) >= div);
        end
    end

    // One compare and subtract per stage; quotient bits shift in at the bottom.
    for (genvar k = 1; k <= QD_STEPS; k++) begin : g_step
        logic [CFG_DATA_W:0] trial;
        logic                ge;
        logic [CFG_DATA_W:0] diff;
        assign trial = {r_rem[k-1], r_bits[k-1][Q_W-1]};
        assign ge = (trial >= {1'b0, div});
        assign diff = trial - {1'b0, div};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[CFG_DATA_W-1:0] : trial[CFG_DATA_W-1:0];
                r_bits[k] <= {r_bits[k-1][Q_W-2:0], ge};
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quo = r_bits[QD_STEPS];
    assign o_sat = r_sat[QD_STEPS];

endmodule
`default_nettype wire

// ===== rtl/seib_back.sv =====
// Back part: quotient dividers, zone test, taper index, weight lookup and blend.
`default_nettype none
module seib_back import seib_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_back_cfg                  i_cfg,
    input  wire logic                  i_q_empty,
    input  t_front_item                i_q_item,
    output logic                       o_q_pop,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [VALUE_W-1:0]         o_new_value,
    output logic                       o_inside_zone
);

    logic                  en;
    logic                  ob_full;

    // Side line carried along the quotient dividers.
    logic                  r_dv_valid [0:QD_STEPS];
    logic [VALUE_W-1:0]    r_dv_value [0:QD_STEPS];
    logic [Q_W-1:0]        quo_p;
    logic [Q_W-1:0]        quo_r;
    logic                  sat_p;
    logic                  sat_r;

    // Zone test.
    logic [Q_W:0]          qsum;
    logic [Q_W:0]          q;
    logic [Q_W:0]          hi_lim;
    logic [QF:0]           lo_lim;
    logic                  outside;
    logic                  wone;
    logic [NUM_W-1:0]      num;
    logic [NUM_W-1:0]      div2;

    // Index divider stages.
    logic                  r_x_valid   [0:IDX_W];
    logic [VALUE_W-1:0]    r_x_value   [0:IDX_W];
    logic                  r_x_outside [0:IDX_W];
    logic                  r_x_wone    [0:IDX_W];
    logic [NUM_W-1:0]      r_x_rem     [0:IDX_W];
    logic [IDX_W-1:0]      r_x_bits    [0:IDX_W];

    // Weight, product and blend.
    logic [IDX_W-1:0]      idx;
    logic                  r_w_valid;
    logic [VALUE_W-1:0]    r_w_value;
    logic                  r_w_outside;
    logic [W_W-1:0]        r_w_weight;
    logic                  r_m_valid;
    logic [VALUE_W-1:0]    r_m_value;
    logic                  r_m_outside;
    logic signed [VALUE_W+W_W+1:0] r_m_prod;
    logic signed [VALUE_W:0]       diff;
    logic signed [ACC_W-1:0]       acc;
    logic [VALUE_W-1:0]    blend;
    logic [VALUE_W-1:0]    res_value;

    // Output buffer of two results.
    logic [VALUE_W-1:0]    r_ob_value  [0:1];
    logic                  r_ob_inside [0:1];
    logic                  r_ob_wp;
    logic                  r_ob_rp;
    logic [1:0]            r_ob_cnt;
    logic                  ob_push;
    logic                  ob_pop;

    // The whole back pipeline stalls only when its last item cannot leave.
    assign ob_full = (r_ob_cnt == 2'd2);
    assign en = !(r_m_valid && ob_full);
    assign o_q_pop = en && !i_q_empty;

    seib_qdiv u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sq  (i_q_item.sq_p),
        .i_div (i_cfg.a_sq),
        .o_quo (quo_p),
        .o_sat (sat_p)
    );

    seib_qdiv u_div_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sq  (i_q_item.sq_r),
        .i_div (i_cfg.b_sq),
        .o_quo (quo_r),
        .o_sat (sat_r)
    );

    // Valid and value travel beside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QD_STEPS; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_valid[0] <= !i_q_empty;
            for (int k = 1; k <= QD_STEPS; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_value[0] <= i_q_item.value;
            for (int k = 1; k <= QD_STEPS; k++) begin
                r_dv_value[k] <= r_dv_value[k-1];
            end
        end
    end

    // Sum the terms, saturate, and classify against 1-t and 1+t.
    always_comb begin
        qsum = {1'b0, quo_p} + {1'b0, quo_r};
        q = (sat_p || sat_r || qsum[Q_W]) ? Q_CAP : qsum;
        hi_lim = (Q_W+1)'(Q_ONE) + (Q_W+1)'(i_cfg.trans);
        lo_lim = Q_ONE - (QF+1)'(i_cfg.trans);
        outside = (q > hi_lim);
        wone = (i_cfg.trans == '0) || (q < (Q_W+1)'(lo_lim));
        num = q[NUM_W-1:0] - lo_lim[NUM_W-1:0];
        div2 = {i_cfg.trans, 1'b0};
    end

    // First index stage holds the start remainder of num * depth / (2t).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= IDX_W; k++) begin
                r_x_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_x_valid[0] <= r_dv_valid[QD_STEPS];
            for (int k = 1; k <= IDX_W; k++) begin
                r_x_valid[k] <= r_x_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_value[0] <= r_dv_value[QD_STEPS];
            r_x_outside[0] <= outside;
            r_x_wone[0] <= wone;
            r_x_rem[0] <= num >> 1;
            r_x_bits[0] <= {num[0], {TAPER_LOG{1'b0}}};
        end
    end

    // Index divider: one quotient bit per stage.
    for (genvar k = 1; k <= IDX_W; k++) begin : g_idx
        logic [NUM_W:0] trial;
        logic           ge;
        logic [NUM_W:0] sub;
        assign trial = {r_x_rem[k-1], r_x_bits[k-1][IDX_W-1]};
        assign ge = (trial >= {1'b0, div2});
        assign sub = trial - {1'b0, div2};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x_value[k] <= r_x_value[k-1];
                r_x_outside[k] <= r_x_outside[k-1];
                r_x_wone[k] <= r_x_wone[k-1];
                r_x_rem[k] <= ge ? sub[NUM_W-1:0] : trial[NUM_W-1:0];
                r_x_bits[k] <= {r_x_bits[k-1][IDX_W-2:0], ge};
            end
        end
    end

    // Weight lookup.
    assign idx = (r_x_bits[IDX_W] > IDX_W'(TAPER_DEPTH)) ? IDX_W'(TAPER_DEPTH)
                                                         : r_x_bits[IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_w_valid <= r_x_valid[IDX_W];
            r_m_valid <= r_w_valid;
        end
    end

    assign diff = $signed({1'b0, i_cfg.target}) - $signed({1'b0, r_w_value});

    // Weight stage, then the product of the difference and the weight.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w_value <= r_x_value[IDX_W];
            r_w_outside <= r_x_outside[IDX_W];
            r_w_weight <= r_x_wone[IDX_W] ? W_ONE : TAPER_TAB[idx];
            r_m_value <= r_w_value;
            r_m_outside <= r_w_outside;
            r_m_prod <= diff * $signed({1'b0, r_w_weight});
        end
    end

    // Round half up, clamp to the value range.
    always_comb begin
        acc = $signed({4'b0000, r_m_value, {(W_W-1){1'b0}}}) + ACC_W'(r_m_prod)
              + $signed(ACC_W'(16384));
        if (acc[ACC_W-1]) begin
            blend = '0;
        end else if (acc[ACC_W-2:VALUE_W+W_W-1] != '0) begin
            blend = {VALUE_W{1'b1}};
        end else begin
            blend = acc[VALUE_W+W_W-2:W_W-1];
        end
        res_value = r_m_outside ? r_m_value : blend;
    end

    // Output buffer.
    assign ob_push = en && r_m_valid;
    assign ob_pop = pop && (r_ob_cnt != 2'd0);
    assign empty = (r_ob_cnt == 2'd0);
    assign o_new_value = r_ob_value[r_ob_rp];
    assign o_inside_zone = r_ob_inside[r_ob_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp <= 1'b0;
            r_ob_rp <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (ob_push) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            if (ob_push && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (ob_pop && !ob_push) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob_value[r_ob_wp] <= res_value;
            r_ob_inside[r_ob_wp] <= !r_m_outside;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/soft_ellipse_inclusion_blend.sv =====
// Top level of the soft ellipse inclusion blend: configuration registers and both parts.
//
// Each voxel enters through a queue-style push/full port and its result leaves through
// an empty/pop port, one result per voxel, in order. The block takes one item per
// cycle and runs items back to back unless a full output buffer that is not popped
// holds it and raises full. An item passes two front stages, the short queue, the
// 49-stage quotient dividers, ten taper index stages (the sum and zone test feed
// the first), the weight stage, the product stage and the output buffer. Results
// equal the input value with the zone flag low when q exceeds one plus the taper
// half width. Configuration registers are written through a plain write port and
// should only change while no item is in flight.
`default_nettype none
module soft_ellipse_inclusion_blend import seib_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [VALUE_W-1:0]    i_voxel_value,
    input  wire logic [COORD_W-1:0]    i_coord_x,
    input  wire logic [COORD_W-1:0]    i_coord_y,
    input  wire logic [COORD_W-1:0]    i_coord_z,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [VALUE_W-1:0]         o_new_value,
    output logic                       o_inside_zone,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [AXIS_W-1:0]     r_axis;
    logic [COORD_W-1:0]    r_center_p;
    logic [COORD_W-1:0]    r_center_q;
    t_back_cfg             r_back_cfg;

    logic                  fq_push;
    logic                  fq_full;
    logic                  fq_pop;
    logic                  fq_empty;
    t_front_item           fq_in;
    t_front_item           fq_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_Z;
            r_center_p <= '0;
            r_center_q <= '0;
            r_back_cfg.a_sq <= CFG_DATA_W'(256);
            r_back_cfg.b_sq <= CFG_DATA_W'(256);
            r_back_cfg.trans <= TRANS_W'(6554);
            r_back_cfg.target <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AXIS:     r_axis <= i_cfg_data[AXIS_W-1:0];
                CFG_CENTER_P: r_center_p <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Q: r_center_q <= i_cfg_data[COORD_W-1:0];
                CFG_A_SQ:     r_back_cfg.a_sq <= i_cfg_data;
                CFG_B_SQ:     r_back_cfg.b_sq <= i_cfg_data;
                CFG_TRANS:    r_back_cfg.trans <= i_cfg_data[TRANS_W-1:0];
                CFG_TARGET:   r_back_cfg.target <= i_cfg_data[VALUE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    seib_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_voxel_value (i_voxel_value),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_axis        (r_axis),
        .i_center_p    (r_center_p),
        .i_center_q    (r_center_q),
        .i_q_full      (fq_full),
        .o_q_push      (fq_push),
        .o_q_item      (fq_in)
    );

    seib_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_item  (fq_in),
        .o_full  (fq_full),
        .i_pop   (fq_pop),
        .o_empty (fq_empty),
        .o_item  (fq_out)
    );

    seib_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_back_cfg),
        .i_q_empty     (fq_empty),
        .i_q_item      (fq_out),
        .o_q_pop       (fq_pop),
        .empty         (empty),
        .pop           (pop),
        .o_new_value   (o_new_value),
        .o_inside_zone (o_inside_zone)
    );

endmodule
`default_nettype wire

// ===== verif/seib_blend_monitor.sv =====
// Watches the voxel and result channels, predicts each blend and compares the results.
`default_nettype none
module seib_blend_monitor import seib_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    input  wire logic                  full,
    input  wire logic [VALUE_W-1:0]    i_voxel_value,
    input  wire logic [COORD_W-1:0]    i_coord_x,
    input  wire logic [COORD_W-1:0]    i_coord_y,
    input  wire logic [COORD_W-1:0]    i_coord_z,
    input  wire logic                  empty,
    input  wire logic                  pop,
    input  wire logic [VALUE_W-1:0]    o_new_value,
    input  wire logic                  o_inside_zone,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               in_zone;
    } blend_t;

    blend_t expected_blends[$];
    logic [W_W-1:0] cos_weight[0:TAPER_DEPTH];

    // Shadow copy of the configuration registers.
    logic [AXIS_W-1:0]     axis_sel;
    logic [COORD_W-1:0]    ctr_p;
    logic [COORD_W-1:0]    ctr_q;
    logic [CFG_DATA_W-1:0] div_a;
    logic [CFG_DATA_W-1:0] div_b;
    logic [TRANS_W-1:0]    half_t;
    logic [VALUE_W-1:0]    target_vel;

    // Cosine weights from a truncated power series in Q2.30, rounded to Q1.15.
    function automatic void fill_cos_weights();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          w;
        for (int i = 0; i <= TAPER_DEPTH; i++) begin
            x = 64'd1686629713 * i / TAPER_DEPTH;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    sum -= term;
                end else begin
                    sum += term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            w = (sum + 16384) >>> 15;
            if (w > 32768) begin
                w = 32768;
            end
            cos_weight[i] = w[W_W-1:0];
        end
    endfunction

    // One squared offset over its divisor in Q.16, saturating at 2^48.
    function automatic longint unsigned scaled_square(logic [COORD_W-1:0] pos,
                                                      logic [COORD_W-1:0] ctr,
                                                      logic [CFG_DATA_W-1:0] div);
        longint          d;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned dv;
        longint unsigned hi;
        longint unsigned lo;
        d = longint'($signed(pos)) - longint'($signed(ctr));
        mag = (d < 0) ? -d : d;
        if (mag > 64'hFFFF_FFFF) begin
            mag = 64'hFFFF_FFFF;
        end
        sq = mag * mag;
        dv = (div == 0) ? 1 : div;
        hi = sq / dv;
        if (hi >= (64'd1 << 40)) begin
            return 64'd1 << 48;
        end
        lo = ((sq % dv) << 8) / dv;
        return (hi << 8) + lo;
    endfunction

    // Expected result for one voxel under the current configuration.
    function automatic blend_t blend_voxel(logic [VALUE_W-1:0] v, logic [COORD_W-1:0] x,
                                           logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        blend_t          res;
        logic [COORD_W-1:0] p;
        logic [COORD_W-1:0] r;
        longint unsigned q;
        longint unsigned t;
        longint unsigned idx;
        longint          w;
        longint          acc;
        if (axis_sel == AXIS_X) begin
            p = y;
            r = z;
        end else if (axis_sel == AXIS_Y) begin
            p = x;
            r = z;
        end else begin
            p = x;
            r = y;
        end
        q = scaled_square(p, ctr_p, div_a) + scaled_square(r, ctr_q, div_b);
        if (q > (64'd1 << 48)) begin
            q = 64'd1 << 48;
        end
        t = half_t;
        if (q > 65536 + t) begin
            res.value = v;
            res.in_zone = 1'b0;
            return res;
        end
        if (t == 0 || q < 65536 - t) begin
            w = 32768;
        end else begin
            idx = (q - (65536 - t)) * TAPER_DEPTH / (2 * t);
            if (idx > TAPER_DEPTH) begin
                idx = TAPER_DEPTH;
            end
            w = cos_weight[idx];
        end
        acc = (longint'(v) << 15) + (longint'(target_vel) - longint'(v)) * w + 16384;
        if (acc < 0) begin
            acc = 0;
        end
        acc = acc >>> 15;
        if (acc > 65535) begin
            acc = 65535;
        end
        res.value = acc[VALUE_W-1:0];
        res.in_zone = 1'b1;
        return res;
    endfunction

    initial begin
        fill_cos_weights();
        fail_count = 0;
    end

    assign pending_count = expected_blends.size();

    // Register writes, accepted voxels and accepted results.
    always @(posedge i_clk) begin
        blend_t want;
        if (!i_rst_n) begin
            axis_sel <= AXIS_Z;
            ctr_p <= '0;
            ctr_q <= '0;
            div_a <= 32'd256;
            div_b <= 32'd256;
            half_t <= 16'd6554;
            target_vel <= '0;
            expected_blends.delete();
        end else begin
            if (push && !full) begin
                expected_blends.push_back(blend_voxel(i_voxel_value, i_coord_x,
                                                      i_coord_y, i_coord_z));
            end
            if (pop && !empty) begin
                if (expected_blends.size() == 0) begin
                    $error("result with no voxel waiting: new_value %0d", o_new_value);
                    fail_count++;
                end else begin
                    want = expected_blends.pop_front();
                    if (o_new_value !== want.value) begin
                        $error("new_value: expected %0d, got %0d", want.value, o_new_value);
                        fail_count++;
                    end
                    if (o_inside_zone !== want.in_zone) begin
                        $error("inside_zone: expected %0d, got %0d", want.in_zone,
                               o_inside_zone);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AXIS: axis_sel <= i_cfg_data[AXIS_W-1:0];
                    CFG_CENTER_P: ctr_p <= i_cfg_data;
                    CFG_CENTER_Q: ctr_q <= i_cfg_data;
                    CFG_A_SQ: div_a <= i_cfg_data;
                    CFG_B_SQ: div_b <= i_cfg_data;
                    CFG_TRANS: half_t <= i_cfg_data[TRANS_W-1:0];
                    CFG_TARGET: target_vel <= i_cfg_data[VALUE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== verif/tb_soft_ellipse_inclusion_blend.sv =====
// Stimulus and verdict for the soft ellipse inclusion blend.
`default_nettype none
module tb_soft_ellipse_inclusion_blend;
    import seib_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 270;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [VALUE_W-1:0]    i_voxel_value;
    logic [COORD_W-1:0]    i_coord_x;
    logic [COORD_W-1:0]    i_coord_y;
    logic [COORD_W-1:0]    i_coord_z;
    logic                  empty;
    logic                  pop;
    logic [VALUE_W-1:0]    o_new_value;
    logic                  o_inside_zone;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count;
    int                    voxels_sent;

    // Current plane axis, center and ellipse radii (in Q.8 offset units) for stimulus.
    logic [AXIS_W-1:0]     cur_axis;
    logic [COORD_W-1:0]    cur_cp;
    logic [COORD_W-1:0]    cur_cq;
    int                    rad_p;
    int                    rad_q;

    soft_ellipse_inclusion_blend dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_voxel_value(i_voxel_value), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_coord_z(i_coord_z), .empty(empty), .pop(pop), .o_new_value(o_new_value),
        .o_inside_zone(o_inside_zone), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    seib_blend_monitor mon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_voxel_value(i_voxel_value), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_coord_z(i_coord_z), .empty(empty), .pop(pop), .o_new_value(o_new_value),
        .o_inside_zone(o_inside_zone), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_soft_ellipse_inclusion_blend failed");
            $finish;
        end
    end

    // Result side: random pops, one long hold-off and one stretch that always pops.
    initial begin
        int pop_cycle;
        pop = 1'b0;
        pop_cycle = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (pop_cycle >= 800 && pop_cycle < 1200) begin
                pop <= 1'b0;
            end else if (pop_cycle >= 1500 && pop_cycle < 2700) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 34);
            end
            pop_cycle++;
            @(posedge i_clk);
        end
    end

    // Offer one voxel, with random idle cycles in front of it outside the busy stretch.
    task automatic send_voxel(logic [VALUE_W-1:0] v, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        while ((voxels_sent < 500 || voxels_sent >= 800) && $urandom_range(99) < 34) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_voxel_value <= v;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        voxels_sent++;
    endtask

    // Voxel with given in-plane offsets from the current center.
    task automatic send_offset(logic [VALUE_W-1:0] v, int dp, int dq);
        logic [COORD_W-1:0] p;
        logic [COORD_W-1:0] q;
        logic [COORD_W-1:0] other;
        p = cur_cp + dp;
        q = cur_cq + dq;
        other = $urandom;
        if (cur_axis == AXIS_X) begin
            send_voxel(v, other, p, q);
        end else if (cur_axis == AXIS_Y) begin
            send_voxel(v, p, other, q);
        end else begin
            send_voxel(v, p, q, other);
        end
    endtask

    // Stop offering and wait until every result is back, plus the pipeline depth.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Load a full register set; radii are the offsets that reach q of one.
    task automatic set_phase(logic [AXIS_W-1:0] axis, logic [COORD_W-1:0] cp,
                             logic [COORD_W-1:0] cq, logic [31:0] a_sq, logic [31:0] b_sq,
                             logic [15:0] trans, logic [15:0] vel, int rp, int rq);
        write_reg(CFG_AXIS, axis);
        write_reg(CFG_CENTER_P, cp);
        write_reg(CFG_CENTER_Q, cq);
        write_reg(CFG_A_SQ, a_sq);
        write_reg(CFG_B_SQ, b_sq);
        write_reg(CFG_TRANS, trans);
        write_reg(CFG_TARGET, vel);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_axis = axis;
        cur_cp = cp;
        cur_cq = cq;
        rad_p = rp;
        rad_q = rq;
    endtask

    // Mostly voxels around the ellipse rim, the rest anywhere.
    task automatic random_phase();
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) < 75) begin
                send_offset($urandom, int'($urandom_range(0, 4 * rad_p)) - 2 * rad_p,
                            int'($urandom_range(0, 4 * rad_q)) - 2 * rad_q);
            end else begin
                send_voxel($urandom, $urandom, $urandom, $urandom);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_voxel_value = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        voxels_sent = 0;
        cur_axis = AXIS_Z;
        cur_cp = '0;
        cur_cq = '0;
        rad_p = 256;
        rad_q = 256;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed voxels under the reset configuration: unit circle, taper of 0.1.
        send_offset(16'd0, 0, 0);
        send_offset(16'hFFFF, 0, 0);
        send_offset(16'd1000, 230, 0);
        send_offset(16'd1000, 0, 248);
        send_offset(16'd1000, 256, 0);
        send_offset(16'd1000, 181, 181);
        send_offset(16'd1000, 0, 262);
        send_offset(16'd1000, 268, 0);
        send_offset(16'd1000, 282, 0);
        send_offset(16'hFFFF, 250, 50);
        send_voxel(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_voxel(16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_voxel(16'h5555, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_voxel(16'hAAAA, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h8000_0000);
        send_voxel(16'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678);
        drain();

        // Register settings, extremes among them; each drain is a full sender pause.
        set_phase(AXIS_X, 32'd1000, -32'sd2000, 32'd65536, 32'd4096, 16'd6554,
                  16'hFFFF, 4096, 1024);
        random_phase();
        set_phase(AXIS_Y, 32'h7FFF_0000, 32'h8001_0000, 32'd1, 32'hFFFF_FFFF, 16'hFFFF,
                  16'd12345, 16, 1048576);
        random_phase();
        set_phase(AXIS_Z, -32'sd5000, 32'd7000, 32'd351, 32'd97656, 16'd1,
                  16'd40000, 300, 5000);
        random_phase();
        // Axis code three and a zero divisor and a zero taper width.
        set_phase(2'd3, 32'd0, 32'd0, 32'd0, 32'd256, 16'd0, 16'hFFFF, 16, 256);
        random_phase();
        set_phase(AXIS_Z, 32'h7FFF_FFFF, 32'h8000_0000, 32'd256, 32'd256, 16'd32768,
                  16'd0, 256, 256);
        random_phase();
        set_phase(AXIS_X, 32'd0, 32'd0, 32'd1048576, 32'd1048576, 16'd100,
                  16'd30000, 16384, 16384);
        random_phase();
        set_phase(AXIS_Y, -32'sd77777, 32'd4242, 32'd2560, 32'd25600, 16'd20000,
                  16'd500, 810, 2560);
        random_phase();

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_soft_ellipse_inclusion_blend passed");
        end else begin
            $display("tb_soft_ellipse_inclusion_blend failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/seib_pkg.sv
rtl/seib_front.sv
rtl/seib_fifo.sv
rtl/seib_qdiv.sv
rtl/seib_back.sv
rtl/soft_ellipse_inclusion_blend.sv
verif/seib_blend_monitor.sv
verif/tb_soft_ellipse_inclusion_blend.sv
